[src/mcdl_pkg.sv]
// Package for the deinterlace line merge: widths, codes and the stage payload type.
// Depends on nothing; every other file of the block but mcdl_ram takes names from here by scope.
`timescale 1ns / 1ps

package mcdl_pkg;

   // Column line store depth
   localparam int MAX_WIDTH = 2048;

   localparam int COL_W  = 11;
   localparam int PIX_W  = 8;
   localparam int DIFF_W = PIX_W + 1;
   localparam int SUM_W  = DIFF_W + 1;
   localparam int NUM_W  = SUM_W + 1;
   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int COL_EXT_W = ADDR_W + COL_W;
   localparam int PIX_MAX = 255;

   // Command codes
   localparam logic CMD_PRIME  = 1'b0;
   localparam logic CMD_INTERP = 1'b1;

   // adjust_mode codes
   localparam logic MODE_MINOR  = 1'b0;
   localparam logic MODE_NORMAL = 1'b1;

   // Interpolate word after the line store read has been issued
   typedef struct packed {
      logic [PIX_W-1:0]  mc_pixel;
      logic [DIFF_W-1:0] d1;
      logic              in_range;
   } mcdl_s1_type;

endpackage

[src/mcdl_if.sv]
// Handshake channels of the deinterlace line merge: request and response words.
// Depends on mcdl_pkg for the field widths.
`timescale 1ns / 1ps

interface mcdl_req_if;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic [mcdl_pkg::COL_W-1:0] column;
   logic [mcdl_pkg::PIX_W-1:0] mc_pixel;
   logic [mcdl_pkg::PIX_W-1:0] mc_real_line_pixel;
   logic [mcdl_pkg::PIX_W-1:0] source_pixel;

   modport source (output valid, cmd, column, mc_pixel, mc_real_line_pixel, source_pixel,
                   input ready);
   modport sink (input valid, cmd, column, mc_pixel, mc_real_line_pixel, source_pixel,
                 output ready);
endinterface

interface mcdl_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mcdl_pkg::PIX_W-1:0] pixel_out;

   modport source (output valid, pixel_out, input ready);
   modport sink (input valid, pixel_out, output ready);
endinterface

[src/mcdl_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// Read-first on a same-address collision. No dependencies.
`timescale 1ns / 1ps

module mcdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read old contents, then write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/mcdl_core.sv]
// Correction pipeline: sum and magnitudes, damped numerator, halve-subtract-clamp.
// Depends on mcdl_pkg and mcdl_rsp_if; fed by the line store stage of the top level.
`timescale 1ns / 1ps

module mcdl_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adjust_mode,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  mcdl_pkg::mcdl_s1_type       in_data,
   input  logic [mcdl_pkg::DIFF_W-1:0] d0_raw,
   mcdl_rsp_if.source                  rsp_ch
);

   localparam int DIFF_W = mcdl_pkg::DIFF_W;
   localparam int SUM_W  = mcdl_pkg::SUM_W;
   localparam int NUM_W  = mcdl_pkg::NUM_W;
   localparam int PIX_W  = mcdl_pkg::PIX_W;

   // Stage registers
   logic                     s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic [PIX_W-1:0]         s2_mc_ff, s3_mc_ff;
   logic signed [SUM_W-1:0]  s2_sum_ff, s2_sum_in;
   logic [PIX_W-1:0]         s2_a0_ff, s2_a0_in, s2_a1_ff, s2_a1_in;
   logic signed [NUM_W-1:0]  s3_num_ff, s3_num_in;
   logic [PIX_W-1:0]         out_pixel_ff, out_pixel_in;

   logic                     s2_take, s3_take, out_take;
   logic signed [DIFF_W-1:0] d0, d1;
   logic [PIX_W-1:0]         gap;
   logic signed [NUM_W-1:0]  half_gap, sum_x, num_adj, corr, val;

   // Each stage moves on when the one ahead is empty or moving
   assign out_take = !out_valid_ff || rsp_ch.ready;
   assign s3_take  = !s3_valid_ff || out_take;
   assign s2_take  = !s2_valid_ff || s3_take;
   assign in_ready = s2_take;

   // Stage 2: select d0, form sum and magnitudes
   always_comb begin
      d0 = in_data.in_range ? $signed(d0_raw) : '0;
      d1 = $signed(in_data.d1);
      s2_sum_in = SUM_W'(d0) + SUM_W'(d1);
      s2_a0_in = d0[DIFF_W-1] ? PIX_W'(-d0) : PIX_W'(d0);
      s2_a1_in = d1[DIFF_W-1] ? PIX_W'(-d1) : PIX_W'(d1);
   end

   // Stage 3: numerator of the correction
   always_comb begin
      gap = (s2_a0_ff >= s2_a1_ff) ? (s2_a0_ff - s2_a1_ff) : (s2_a1_ff - s2_a0_ff);
      half_gap = $signed(NUM_W'(gap >> 1));
      sum_x = NUM_W'(s2_sum_ff);
      if (adjust_mode == mcdl_pkg::MODE_NORMAL) begin
         s3_num_in = sum_x;
      end else if (s2_sum_ff > 0) begin
         s3_num_in = sum_x - half_gap;
      end else begin
         s3_num_in = sum_x + half_gap;
      end
   end

   // Output stage: halve toward zero, subtract, clamp
   always_comb begin
      num_adj = s3_num_ff + $signed(NUM_W'(s3_num_ff[NUM_W-1]));
      corr = num_adj >>> 1;
      val = $signed(NUM_W'(s3_mc_ff)) - corr;
      if (val < 0) begin
         out_pixel_in = '0;
      end else if (val > $signed(NUM_W'(mcdl_pkg::PIX_MAX))) begin
         out_pixel_in = PIX_W'(mcdl_pkg::PIX_MAX);
      end else begin
         out_pixel_in = val[PIX_W-1:0];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s2_take) begin
            s2_valid_ff <= in_valid;
         end
         if (s3_take) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_take) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Advance payload, hold on stall
   always_ff @(posedge clock) begin
      if (s2_take && in_valid) begin
         s2_mc_ff  <= in_data.mc_pixel;
         s2_sum_ff <= s2_sum_in;
         s2_a0_ff  <= s2_a0_in;
         s2_a1_ff  <= s2_a1_in;
      end
      if (s3_take && s2_valid_ff) begin
         s3_mc_ff  <= s2_mc_ff;
         s3_num_ff <= s3_num_in;
      end
      if (out_take && s3_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.pixel_out = out_pixel_ff;

endmodule

[src/mc_deinterlace_line_merge_unit.sv]
// Top level of the deinterlace line merge: request stage, column line store, mode register.
// Depends on mcdl_pkg, mcdl_if, mcdl_ram and mcdl_core.
`timescale 1ns / 1ps

// Takes one request word per clock unless a response stall has filled the pipe. A
// prime word writes the column difference (compensated minus source) of a real line
// and gives no response. An interpolate word reads the stored difference of its column,
// stores the new one and presents one corrected pixel via stage 2 and stage 3 from the
// output stage. The column line store does its read and its write of the same entry
// in the accept cycle (read-first), so words for the same column may follow each other
// in consecutive clocks. Responses come in request order; a stall on the response
// side backs up through four register stages before the request side sees it.
// The line store is not cleared after reset: interpolating a column that has never
// been written gives an undefined pixel. Write adjust_mode only while the block is idle.
module mc_deinterlace_line_merge_unit (
   input  logic         clock,
   input  logic         reset,
   mcdl_req_if.sink     req_ch,
   mcdl_rsp_if.source   rsp_ch,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   localparam int ADDR_W    = mcdl_pkg::ADDR_W;
   localparam int COL_EXT_W = mcdl_pkg::COL_EXT_W;
   localparam int DIFF_W    = mcdl_pkg::DIFF_W;

   logic                   adjust_mode_ff;
   logic                   s1_valid_ff, s1_valid_in;
   mcdl_pkg::mcdl_s1_type  s1_data_ff, s1_data_in;

   logic                   core_ready, req_accept, is_interp, in_range;
   logic [COL_EXT_W-1:0]   col_ext;
   logic [ADDR_W-1:0]      ram_addr;
   logic [DIFF_W-1:0]      d1, ram_rd_data;

   // Request side: take a word when stage one is free or moving on
   assign req_ch.ready = !s1_valid_ff || core_ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign is_interp    = (req_ch.cmd == mcdl_pkg::CMD_INTERP);

   assign col_ext  = COL_EXT_W'(req_ch.column);
   assign ram_addr = col_ext[ADDR_W-1:0];
   assign in_range = col_ext < COL_EXT_W'(mcdl_pkg::MAX_WIDTH);
   assign d1 = DIFF_W'({1'b0, req_ch.mc_real_line_pixel}) -
               DIFF_W'({1'b0, req_ch.source_pixel});

   // Primes leave the pipe here; interpolates go on
   always_comb begin
      s1_valid_in = s1_valid_ff && !core_ready;
      s1_data_in  = s1_data_ff;
      if (req_accept) begin
         s1_valid_in         = is_interp;
         s1_data_in.mc_pixel = req_ch.mc_pixel;
         s1_data_in.d1       = d1;
         s1_data_in.in_range = in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         adjust_mode_ff <= mcdl_pkg::MODE_MINOR;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_wr_en) begin
            adjust_mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
   end

   // Column line store
   mcdl_ram #(
      .WIDTH (DIFF_W),
      .DEPTH (mcdl_pkg::MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_accept && in_range),
      .wr_addr (ram_addr),
      .wr_data (d1),
      .rd_en   (req_accept && is_interp),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   mcdl_core u_core (
      .clock       (clock),
      .reset       (reset),
      .adjust_mode (adjust_mode_ff),
      .in_valid    (s1_valid_ff),
      .in_ready    (core_ready),
      .in_data     (s1_data_ff),
      .d0_raw      (ram_rd_data),
      .rsp_ch      (rsp_ch)
   );

`ifndef SYNTH
   // A prime word never enters the correction pipe
   a_prime_dropped: assert property (@(posedge clock) disable iff (reset)
      req_accept && !is_interp |=> !s1_valid_ff)
      else $error("prime word entered correction pipe");

   // An interpolate word always enters it
   a_interp_kept: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_interp |=> s1_valid_ff)
      else $error("interpolate word lost at stage one");

   // A stalled stage one holds its word
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !core_ready |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("stage one word changed while stalled");
`endif

endmodule
